### design/srgb_pixel_desaturate_macros.svh
// assertion macros for the desaturator port checker
`ifndef SRGB_PIXEL_DESATURATE_MACROS_SVH
`define SRGB_PIXEL_DESATURATE_MACROS_SVH

// same-cycle implication
`define SRGBD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication with a delay set by the argument n
`define SRGBD_ASSERT_DLY(label, clk, rst_n, ante, n, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##n (cons)) \
		else $error(msg);

`endif

### design/srgbd_pkg.sv
// types, constants and table builders for the srgb desaturator
package srgbd_pkg;

	localparam int unsigned CH_W             = 8;
	localparam int unsigned LIN_W            = 16;
	localparam int unsigned SAT_W            = 9;
	localparam int unsigned PROD_W           = 32;
	localparam int unsigned MIX_W            = 25;
	localparam int unsigned NUM_LANES        = 3;
	localparam int unsigned ENC_BITS_DEFAULT = 12;
	localparam int unsigned ENC_BITS_MAX     = 16;
	localparam int unsigned THR_W            = ENC_BITS_MAX + 1;
	localparam int unsigned DEC_DEPTH        = 256;
	localparam int unsigned SEARCH_STEPS     = CH_W;
	localparam int unsigned ARITH_STAGES     = 5;
	localparam int unsigned PIPE_STAGES      = ARITH_STAGES + SEARCH_STEPS;
	localparam int unsigned BIG_W            = 416;

	localparam logic [SAT_W-1:0] SAT_FULL = 9'd256;
	localparam logic [LIN_W-1:0] LIN_MAX  = 16'hFFFF;

	// luma weights in Q0.16, lane order red, green, blue; they sum to 65536
	localparam logic [NUM_LANES-1:0][LIN_W-1:0] LUMA_WEIGHT = {16'd4732, 16'd46871, 16'd13933};

	typedef logic [BIG_W-1:0] big_t;
	typedef logic [DEC_DEPTH-1:0][LIN_W-1:0] dec_rom_t;
	typedef logic [DEC_DEPTH-1:0][THR_W-1:0] enc_thr_t;

	// 1.055 * 255000 rescaled: decode base (1000*v + 14025) / 269025
	localparam int unsigned DEC_DEN = 269025;

	function automatic big_t big_pow(input big_t base, input int unsigned e);
		big_t acc;
		acc = big_t'(1);
		for (int unsigned j = 0; j < e; j++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// round(65535 * decode(i/255)), exact integer search on the 2.4 power
	function automatic dec_rom_t build_dec_rom();
		dec_rom_t    rom;
		big_t        c12;
		big_t        lhs;
		big_t        rhs;
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		rom = '0;
		c12 = big_pow(big_t'(DEC_DEN), 12);
		for (int unsigned i = 0; i < DEC_DEPTH; i++) begin
			if (i <= 10) begin
				rom[i[7:0]] = 16'((1310700 * i + 32946) / 65892);
			end else begin
				lhs = big_pow(big_t'(1000 * i + 14025), 12) * big_pow(big_t'(131070), 5);
				lo  = 0;
				hi  = 65535;
				while (lo < hi) begin
					mid = (lo + hi + 1) >> 1;
					rhs = c12 * big_pow(big_t'(2 * mid - 1), 5);
					if (lhs >= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				rom[i[7:0]] = 16'(lo);
			end
		end
		return rom;
	endfunction

	// first encode index whose code reaches k; 2^eb when no index does
	function automatic enc_thr_t build_enc_thr(input int unsigned eb);
		enc_thr_t          thr;
		big_t              c12;
		big_t              lim;
		longint unsigned   top;
		longint unsigned   lo;
		longint unsigned   hi;
		longint unsigned   mid;
		longint unsigned   kk;
		bit                hit;
		thr = '0;
		c12 = big_pow(big_t'(DEC_DEN), 12);
		top = 64'd1 << eb;
		for (int unsigned k = 1; k < DEC_DEPTH; k++) begin
			kk  = 64'(k);
			lim = big_pow(big_t'(1000 * k + 14025), 12) << (5 * eb);
			lo  = 0;
			hi  = top;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (mid * 64'd10000000 <= (64'd31308 << eb)) begin
					hit = (64'd32946 * mid >= kk * (64'd10 << eb));
				end else begin
					hit = (c12 * big_pow(big_t'(mid), 5) >= lim);
				end
				if (hit) begin
					hi = mid;
				end else begin
					lo = mid + 1;
				end
			end
			thr[k[7:0]] = THR_W'(lo);
		end
		return thr;
	endfunction

	localparam dec_rom_t DEC_ROM = build_dec_rom();

endpackage

### design/srgbd_decode_lane.sv
// one channel: srgb to linear table read, then weighted luma product
module srgbd_decode_lane (
	input  logic                          clk,
	input  logic [srgbd_pkg::CH_W-1:0]    chan,
	input  logic [srgbd_pkg::LIN_W-1:0]   weight,
	output logic [srgbd_pkg::LIN_W-1:0]   lin_s2,
	output logic [srgbd_pkg::PROD_W-1:0]  prod_s2
);

	logic [srgbd_pkg::LIN_W-1:0] lin_s1;

	always_ff @(posedge clk) begin
		lin_s1  <= srgbd_pkg::DEC_ROM[chan];
		lin_s2  <= lin_s1;
		prod_s2 <= {16'b0, lin_s1} * {16'b0, weight};
	end

endmodule

### design/srgbd_luma_merge.sv
// merges the three lane products into one luma value
module srgbd_luma_merge (
	input  logic                                                clk,
	input  logic [srgbd_pkg::NUM_LANES-1:0][srgbd_pkg::PROD_W-1:0] prod_s2,
	output logic [srgbd_pkg::LIN_W-1:0]                         luma_s3
);

	logic [srgbd_pkg::PROD_W-1:0] sum_w;

	// weights sum to 1.0 in Q0.16, so the total stays below 2^32
	assign sum_w = prod_s2[0] + prod_s2[1] + prod_s2[2];

	always_ff @(posedge clk) begin
		luma_s3 <= sum_w[srgbd_pkg::PROD_W-1 -: srgbd_pkg::LIN_W];
	end

endmodule

### design/srgbd_enc_search.sv
// linear to srgb encode as a pipelined binary search over code thresholds
module srgbd_enc_search #(
	parameter int unsigned ENC_BITS = srgbd_pkg::ENC_BITS_DEFAULT
) (
	input  logic                        clk,
	input  logic [ENC_BITS-1:0]         idx,
	output logic [srgbd_pkg::CH_W-1:0]  code
);

	localparam int unsigned STEPS = srgbd_pkg::SEARCH_STEPS;
	localparam srgbd_pkg::enc_thr_t ENC_THR = srgbd_pkg::build_enc_thr(ENC_BITS);

	logic [srgbd_pkg::CH_W-1:0] code_s  [STEPS];
	logic [ENC_BITS-1:0]        idx_s   [STEPS];
	logic [srgbd_pkg::CH_W-1:0] code_w  [STEPS];
	logic [ENC_BITS-1:0]        idx_w   [STEPS];
	logic [srgbd_pkg::CH_W-1:0] cand_w  [STEPS];
	logic                       take_w  [STEPS];

	for (genvar s = 0; s < STEPS; s++) begin : g_step
		if (s == 0) begin : g_first
			assign code_w[s] = '0;
			assign idx_w[s]  = idx;
		end else begin : g_next
			assign code_w[s] = code_s[s-1];
			assign idx_w[s]  = idx_s[s-1];
		end

		// try the next code bit, msb first
		assign cand_w[s] = code_w[s] | (srgbd_pkg::CH_W'(1) << (STEPS - 1 - s));
		assign take_w[s] = ENC_THR[cand_w[s]][ENC_BITS:0] <= {1'b0, idx_w[s]};

		always_ff @(posedge clk) begin
			idx_s[s]  <= idx_w[s];
			code_s[s] <= take_w[s] ? cand_w[s] : code_w[s];
		end
	end

	assign code = code_s[STEPS-1];

endmodule

### design/srgbd_mix_lane.sv
// one channel: blend linear value with luma, clamp, encode back to srgb
module srgbd_mix_lane #(
	parameter int unsigned ENC_BITS = srgbd_pkg::ENC_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic [srgbd_pkg::LIN_W-1:0]  lin_s2,
	input  logic [srgbd_pkg::LIN_W-1:0]  luma_s3,
	input  logic [srgbd_pkg::SAT_W-1:0]  sat,
	input  logic [srgbd_pkg::SAT_W-1:0]  sat_inv,
	output logic [srgbd_pkg::CH_W-1:0]   code
);

	localparam int unsigned SUM_W = srgbd_pkg::MIX_W + 1;
	localparam int unsigned SHR_W = SUM_W - 8;

	logic [srgbd_pkg::LIN_W-1:0] lin_s3;
	logic [srgbd_pkg::MIX_W-1:0] p_lin_s4;
	logic [srgbd_pkg::MIX_W-1:0] p_luma_s4;
	logic [ENC_BITS-1:0]         idx_s5;
	logic [SUM_W-1:0]            sum_w;
	logic [SHR_W-1:0]            mixed_w;
	logic [srgbd_pkg::LIN_W-1:0] clamp_w;

	assign sum_w   = {1'b0, p_lin_s4} + {1'b0, p_luma_s4};
	assign mixed_w = sum_w[SUM_W-1:8];
	assign clamp_w = (mixed_w > SHR_W'(srgbd_pkg::LIN_MAX)) ? srgbd_pkg::LIN_MAX
		: mixed_w[srgbd_pkg::LIN_W-1:0];

	always_ff @(posedge clk) begin
		lin_s3    <= lin_s2;
		p_lin_s4  <= {16'b0, sat} * {9'b0, lin_s3};
		p_luma_s4 <= {16'b0, sat_inv} * {9'b0, luma_s3};
		idx_s5    <= clamp_w[srgbd_pkg::LIN_W-1 -: ENC_BITS];
	end

	srgbd_enc_search #(
		.ENC_BITS (ENC_BITS)
	) u_enc (
		.clk  (clk),
		.idx  (idx_s5),
		.code (code)
	);

endmodule

### design/srgb_pixel_desaturate.sv
// top level of the linear-light srgb pixel desaturator
//
// channel    dir  handshake               word
// pixel in   in   start, busy             red_in, green_in, blue_in
// pixel out  out  done, one cycle         red_out, green_out, blue_out
// config     in   cfg_we                  cfg_wdata (saturation, 0..256)
//
// one pixel per clock; busy stays low, so start alone takes a pixel
// done follows the start edge through five arithmetic stages (table read,
// luma products, luma sum, blend products, clamp) and an eight-step
// pipelined search of the encode thresholds
// reset clears the valid pipeline and sets saturation to 256
// the receiver cannot stall: each word stands on the outputs for one cycle
module srgb_pixel_desaturate #(
	parameter int unsigned ENC_BITS = srgbd_pkg::ENC_BITS_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [srgbd_pkg::CH_W-1:0]   red_in,
	input  logic [srgbd_pkg::CH_W-1:0]   green_in,
	input  logic [srgbd_pkg::CH_W-1:0]   blue_in,
	output logic                         done,
	output logic [srgbd_pkg::CH_W-1:0]   red_out,
	output logic [srgbd_pkg::CH_W-1:0]   green_out,
	output logic [srgbd_pkg::CH_W-1:0]   blue_out,
	input  logic                         cfg_we,
	input  logic [srgbd_pkg::SAT_W-1:0]  cfg_wdata
);

	localparam int unsigned LANES  = srgbd_pkg::NUM_LANES;
	localparam int unsigned STAGES = srgbd_pkg::PIPE_STAGES;

	logic [srgbd_pkg::SAT_W-1:0]                   sat_q;
	logic [srgbd_pkg::SAT_W-1:0]                   sat_inv;
	logic [STAGES-1:0]                             vld_q;
	logic [LANES-1:0][srgbd_pkg::CH_W-1:0]         chan_w;
	logic [LANES-1:0][srgbd_pkg::LIN_W-1:0]        lin_s2;
	logic [LANES-1:0][srgbd_pkg::PROD_W-1:0]       prod_s2;
	logic [srgbd_pkg::LIN_W-1:0]                   luma_s3;
	logic [LANES-1:0][srgbd_pkg::CH_W-1:0]         code_w;

	assign busy = 1'b0;

	// saturation above full scale behaves as full scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= srgbd_pkg::SAT_FULL;
		end else if (cfg_we) begin
			sat_q <= (cfg_wdata > srgbd_pkg::SAT_FULL) ? srgbd_pkg::SAT_FULL : cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[STAGES-2:0], start && !busy};
		end
	end

	assign sat_inv = srgbd_pkg::SAT_FULL - sat_q;

	assign chan_w[0] = red_in;
	assign chan_w[1] = green_in;
	assign chan_w[2] = blue_in;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		srgbd_decode_lane u_dec (
			.clk     (clk),
			.chan    (chan_w[l]),
			.weight  (srgbd_pkg::LUMA_WEIGHT[l]),
			.lin_s2  (lin_s2[l]),
			.prod_s2 (prod_s2[l])
		);

		srgbd_mix_lane #(
			.ENC_BITS (ENC_BITS)
		) u_mix (
			.clk     (clk),
			.lin_s2  (lin_s2[l]),
			.luma_s3 (luma_s3),
			.sat     (sat_q),
			.sat_inv (sat_inv),
			.code    (code_w[l])
		);
	end

	srgbd_luma_merge u_merge (
		.clk     (clk),
		.prod_s2 (prod_s2),
		.luma_s3 (luma_s3)
	);

	assign done      = vld_q[STAGES-1];
	assign red_out   = code_w[0];
	assign green_out = code_w[1];
	assign blue_out  = code_w[2];

endmodule

### design/srgbd_port_check.sv
// port-level checks for the desaturator, bound to the top level
`include "srgb_pixel_desaturate_macros.svh"

module srgbd_port_check (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic [srgbd_pkg::CH_W-1:0]  red_in,
	input logic [srgbd_pkg::CH_W-1:0]  green_in,
	input logic [srgbd_pkg::CH_W-1:0]  blue_in,
	input logic                        done,
	input logic [srgbd_pkg::CH_W-1:0]  red_out,
	input logic [srgbd_pkg::CH_W-1:0]  green_out,
	input logic [srgbd_pkg::CH_W-1:0]  blue_out
);

	localparam int unsigned LAT = srgbd_pkg::PIPE_STAGES;

	// every accepted word comes out with done once it has run through the pipeline
	`SRGBD_ASSERT_DLY(a_done_after_start, clk, arst_n, start && !busy, LAT, done, "word accepted but no done after pipeline latency")

	// no word comes out that was not taken in
	`SRGBD_ASSERT_IMP(a_done_has_start, clk, arst_n, done, $past(start && !busy, LAT), "done without a matching accepted word")

	// grey in gives grey out: luma equals the common linear value
	`SRGBD_ASSERT_DLY(a_grey_stays_grey, clk, arst_n, start && !busy && red_in == green_in && green_in == blue_in, LAT, red_out == green_out && green_out == blue_out, "grey pixel came out with unequal channels")

endmodule

bind srgb_pixel_desaturate srgbd_port_check u_port_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.red_in    (red_in),
	.green_in  (green_in),
	.blue_in   (blue_in),
	.done      (done),
	.red_out   (red_out),
	.green_out (green_out),
	.blue_out  (blue_out)
);

### bench/tb_srgb_pixel_desaturate.sv
// testbench for the srgb pixel desaturator: directed and random pixels against a built-in predictor
`timescale 1ns / 100ps

module tb_srgb_pixel_desaturate;

	localparam int unsigned ENC_BITS     = srgbd_pkg::ENC_BITS_DEFAULT;
	localparam int unsigned ENC_SIZE     = 1 << ENC_BITS;
	localparam int unsigned WIDE_W       = 352;
	localparam int unsigned SETTLE       = srgbd_pkg::PIPE_STAGES + 4;
	localparam int unsigned LIMIT_CYCLES = 100000;
	localparam int unsigned DECODE_DEN   = 269025;  // 1.055 * 255000
	localparam int unsigned WEIGHT_RED   = 13933;
	localparam int unsigned WEIGHT_GREEN = 46871;
	localparam int unsigned WEIGHT_BLUE  = 4732;

	typedef logic [WIDE_W-1:0] wide_t;

	typedef struct packed {
		logic [srgbd_pkg::CH_W-1:0] red;
		logic [srgbd_pkg::CH_W-1:0] green;
		logic [srgbd_pkg::CH_W-1:0] blue;
	} pixel_t;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	logic [srgbd_pkg::CH_W-1:0]    red_in;
	logic [srgbd_pkg::CH_W-1:0]    green_in;
	logic [srgbd_pkg::CH_W-1:0]    blue_in;
	logic                          done;
	logic [srgbd_pkg::CH_W-1:0]    red_out;
	logic [srgbd_pkg::CH_W-1:0]    green_out;
	logic [srgbd_pkg::CH_W-1:0]    blue_out;
	logic                          cfg_we;
	logic [srgbd_pkg::SAT_W-1:0]   cfg_wdata;

	logic [srgbd_pkg::LIN_W-1:0]   lin_of_code [srgbd_pkg::DEC_DEPTH];
	logic [srgbd_pkg::CH_W-1:0]    code_of_lin [ENC_SIZE];
	logic [srgbd_pkg::SAT_W-1:0]   sat_cfg;
	pixel_t                        pending_pixels [$];
	pixel_t                        expected_now;
	bit                            gaps_on;
	int unsigned                   error_count;
	int unsigned                   cycle_count;

	srgb_pixel_desaturate #(
		.ENC_BITS(ENC_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.done     (done),
		.red_out  (red_out),
		.green_out(green_out),
		.blue_out (blue_out),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic wide_t wide_pow(input wide_t base, input int unsigned e);
		wide_t acc;
		acc = wide_t'(1);
		for (int unsigned j = 0; j < e; j++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// transfer tables from exact integer comparisons on the 2.4 power
	initial begin : build_transfer_tables
		wide_t             c12;
		wide_t             lhs;
		wide_t             rhs;
		wide_t             thr [srgbd_pkg::DEC_DEPTH];
		int unsigned       lo;
		int unsigned       hi;
		int unsigned       mid;
		longint unsigned   li;
		c12 = wide_pow(wide_t'(DECODE_DEN), 12);
		for (int unsigned i = 0; i < srgbd_pkg::DEC_DEPTH; i++) begin
			if (i <= 10) begin
				lin_of_code[i] = srgbd_pkg::LIN_W'((1310700 * i + 32946) / 65892);
			end else begin
				lhs = wide_pow(wide_t'(1000 * i + 14025), 12) * wide_pow(wide_t'(131070), 5);
				lo  = 0;
				hi  = 65535;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					rhs = c12 * wide_pow(wide_t'(2 * mid - 1), 5);
					if (lhs >= rhs) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				lin_of_code[i] = srgbd_pkg::LIN_W'(lo);
			end
		end
		thr[0] = '0;
		for (int unsigned k = 1; k < srgbd_pkg::DEC_DEPTH; k++) begin
			thr[k] = wide_pow(wide_t'(1000 * k + 14025), 12) << (5 * ENC_BITS);
		end
		for (int unsigned i = 0; i < ENC_SIZE; i++) begin
			li = 64'(i);
			// linear segment of the encode curve below 0.0031308
			if (li * 64'd10000000 <= (64'd31308 << ENC_BITS)) begin
				code_of_lin[i] = srgbd_pkg::CH_W'((64'd32946 * li) / (64'd10 << ENC_BITS));
			end else begin
				lhs = c12 * wide_pow(wide_t'(i), 5);
				lo  = 0;
				hi  = 255;
				while (lo < hi) begin
					mid = (lo + hi + 1) / 2;
					if (lhs >= thr[mid]) begin
						lo = mid;
					end else begin
						hi = mid - 1;
					end
				end
				code_of_lin[i] = srgbd_pkg::CH_W'(lo);
			end
		end
	end

	function automatic logic [srgbd_pkg::CH_W-1:0] blend_channel(input logic [31:0] lin,
		input logic [31:0] luma, input logic [31:0] sat);
		logic [31:0] v;
		v = (sat * lin + (32'd256 - sat) * luma) >> 8;
		if (v > 32'(srgbd_pkg::LIN_MAX)) begin
			v = 32'(srgbd_pkg::LIN_MAX);
		end
		return code_of_lin[v[srgbd_pkg::LIN_W-1 -: ENC_BITS]];
	endfunction

	function automatic pixel_t desaturate_pixel(input pixel_t px,
		input logic [srgbd_pkg::SAT_W-1:0] cfg);
		logic [31:0] sat;
		logic [31:0] lin_r;
		logic [31:0] lin_g;
		logic [31:0] lin_b;
		logic [31:0] luma;
		pixel_t      q;
		// anything above full scale mixes as full scale
		sat   = (cfg > srgbd_pkg::SAT_FULL) ? 32'(srgbd_pkg::SAT_FULL) : 32'(cfg);
		lin_r = 32'(lin_of_code[px.red]);
		lin_g = 32'(lin_of_code[px.green]);
		lin_b = 32'(lin_of_code[px.blue]);
		luma  = (WEIGHT_RED * lin_r + WEIGHT_GREEN * lin_g + WEIGHT_BLUE * lin_b) >> 16;
		q.red   = blend_channel(lin_r, luma, sat);
		q.green = blend_channel(lin_g, luma, sat);
		q.blue  = blend_channel(lin_b, luma, sat);
		return q;
	endfunction

	function automatic logic [srgbd_pkg::CH_W-1:0] rand_channel();
		if ($urandom_range(0, 7) == 0) begin
			return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		end
		return srgbd_pkg::CH_W'($urandom_range(0, 255));
	endfunction

	task automatic log_mismatch(input string what, input logic [srgbd_pkg::CH_W-1:0] want,
		input logic [srgbd_pkg::CH_W-1:0] got);
		if (error_count < 10) begin
			$display("%0t: %s mismatch: expected %0d, got %0d", $realtime, what, want, got);
		end
		error_count++;
	endtask

	task automatic send_pixel(input logic [srgbd_pkg::CH_W-1:0] r,
		input logic [srgbd_pkg::CH_W-1:0] g, input logic [srgbd_pkg::CH_W-1:0] b);
		pixel_t px;
		px = '{red: r, green: g, blue: b};
		while (gaps_on && $urandom_range(0, 99) < 16) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start    <= 1'b1;
		red_in   <= r;
		green_in <= g;
		blue_in  <= b;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		pending_pixels.push_back(desaturate_pixel(px, sat_cfg));
	endtask

	// drop start, let every word come out, then let the pipeline run empty
	task automatic settle_pipeline();
		start <= 1'b0;
		while (pending_pixels.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_saturation(input logic [srgbd_pkg::SAT_W-1:0] value);
		settle_pipeline();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we  <= 1'b0;
		sat_cfg  = value;
	endtask

	// reset setting: colour passes, white lands on the last encode entry
	task automatic test_colour_kept();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd10, 8'd10, 8'd10);
		send_pixel(8'd11, 8'd11, 8'd11);
		send_pixel(8'd1, 8'd2, 8'd3);
		send_pixel(8'h55, 8'hAA, 8'h0F);
	endtask

	task automatic test_greyscale();
		write_saturation('0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd128, 8'd64, 8'd200);
	endtask

	task automatic test_over_range();
		write_saturation('1);
		send_pixel(8'h55, 8'hAA, 8'hF0);
		send_pixel(8'd200, 8'd30, 8'd90);
		write_saturation(srgbd_pkg::SAT_FULL + 9'd1);
		send_pixel(8'd10, 8'd200, 8'd11);
	endtask

	task automatic test_partial_mix();
		write_saturation(9'd1);
		send_pixel(8'd255, 8'd0, 8'd128);
		write_saturation(srgbd_pkg::SAT_FULL - 9'd1);
		send_pixel(8'd0, 8'd255, 8'd128);
		write_saturation(9'd128);
		send_pixel(8'd37, 8'd180, 8'd99);
	endtask

	task automatic test_random_mix();
		logic [srgbd_pkg::CH_W-1:0]  r;
		logic [srgbd_pkg::CH_W-1:0]  g;
		logic [srgbd_pkg::CH_W-1:0]  b;
		logic [srgbd_pkg::SAT_W-1:0] sat;
		for (int p = 0; p < 8; p++) begin
			case ($urandom_range(0, 5))
				0: sat = '0;
				1: sat = srgbd_pkg::SAT_FULL;
				2: sat = '1;
				default: sat = srgbd_pkg::SAT_W'($urandom_range(0, 511));
			endcase
			write_saturation(sat);
			gaps_on = (p != 2);
			for (int n = 0; n < 100; n++) begin
				r = rand_channel();
				g = rand_channel();
				b = rand_channel();
				if ($urandom_range(0, 7) == 0) begin
					g = r;
					b = r;
				end
				send_pixel(r, g, b);
			end
		end
		gaps_on = 1'b1;
	endtask

	// each done word is matched against the oldest pixel still waiting
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_pixels.size() == 0) begin
				log_mismatch("unexpected word, red", 8'h00, red_out);
			end else begin
				expected_now = pending_pixels.pop_front();
				if (red_out !== expected_now.red) begin
					log_mismatch("red", expected_now.red, red_out);
				end
				if (green_out !== expected_now.green) begin
					log_mismatch("green", expected_now.green, green_out);
				end
				if (blue_out !== expected_now.blue) begin
					log_mismatch("blue", expected_now.blue, blue_out);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		red_in      = '0;
		green_in    = '0;
		blue_in     = '0;
		cfg_we      = 1'b0;
		cfg_wdata   = '0;
		sat_cfg     = srgbd_pkg::SAT_FULL;
		gaps_on     = 1'b1;
		error_count = 0;
		cycle_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_colour_kept();
		test_greyscale();
		test_over_range();
		test_partial_mix();
		test_random_mix();
		settle_pipeline();
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
